>>> hw/rtl/sample_statistics_unit_assert.svh
// ============================================================================
// sample_statistics_unit_assert.svh
// Assertion macros for the sample statistics unit. Each macro expects i_clk
// and i_rst_n in scope and stays silent while reset is held.
// ============================================================================
`ifndef SAMPLE_STATISTICS_UNIT_ASSERT_SVH
`define SAMPLE_STATISTICS_UNIT_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define SSU_CHECK_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SSU_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/ssu_pkg.sv
// ============================================================================
// ssu_pkg
// Field widths, datapath sizes and sequencer states of the sample statistics
// unit.
// ============================================================================
package ssu_pkg;

    // Set limits
    localparam int MAX_SAMPLES   = 1024;
    localparam int SAMPLE_BITS   = 16;
    localparam int FRACTION_BITS = 8;

    // Result field widths
    localparam int COUNT_W = 11;
    localparam int SUM_W   = 26;
    localparam int SQSUM_W = 41;
    localparam int MEAN_W  = 24;
    localparam int VAR_W   = 39;
    localparam int DEV_W   = 24;

    // Square of one sample, always non-negative
    localparam int SQUARE_W = 2 * SAMPLE_BITS - 1;

    // Shared adder width and iteration sizes
    localparam int DP_W   = 64;
    localparam int NUM_W  = COUNT_W + SQSUM_W - 1;          // n*sumsq - sum^2
    localparam int DIV_W  = NUM_W + 2 * FRACTION_BITS;      // dividend bits
    localparam int RAD_W  = 2 * DEV_W;                      // root radicand
    localparam int STEP_W = $clog2(DIV_W);

    typedef logic [STEP_W-1:0] t_step;

    // Post-processing sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_MUL_NSQ,
        ST_MUL_SS,
        ST_SUB_NUM,
        ST_MUL_DEN,
        ST_DIV_MEAN,
        ST_DIV_VAR,
        ST_SQRT,
        ST_FINISH
    } t_state;

endpackage

>>> hw/rtl/sample_statistics_unit.sv
// ============================================================================
// sample_statistics_unit
// Running count, sum and sum of squares over a set of signed samples; on the
// closing sample reports count, sum, mean, sample variance and deviation.
// ============================================================================
//
//  channel | valid       | stall        | payload
//  --------+-------------+--------------+--------------------------------------
//  input   | i_in_valid  | o_in_stall   | i_sample_value, i_last_sample
//  output  | o_out_valid | i_out_stall  | o_sample_count .. o_capacity_exceeded
//
//  One sample beat per cycle while a set is being accumulated.
//  After the closing beat the input stalls until the result is loaded (a set of
//  one sample skips the variance division and root): multiply, long division
//  and root all run bit by bit through one shared 64-bit add/subtract unit.
//  Synchronous active-low reset clears accumulators, sequencer and output valid.
//  A pending result is held in the output register; a new set may be taken
//  meanwhile, and only its final load waits for that register to free up.
//
module sample_statistics_unit
    import ssu_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    input  logic                     i_last_sample,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [COUNT_W-1:0]       o_sample_count,
    output logic signed [SUM_W-1:0]  o_total_sum,
    output logic signed [MEAN_W-1:0] o_mean_q8,
    output logic [VAR_W-1:0]         o_variance_q8,
    output logic [DEV_W-1:0]         o_deviation_q8,
    output logic                     o_variance_valid,
    output logic                     o_capacity_exceeded
);

    // Accumulators
    logic [COUNT_W-1:0]  r_count;
    logic [SUM_W-1:0]    r_sum;
    logic [SQSUM_W-1:0]  r_sumsq;
    logic                r_dropped;
    logic [SQUARE_W-1:0] r_square;
    logic                r_sq_pend;

    // Sequencer and working registers
    t_state              r_state, n_state;
    t_step               r_step, n_step;
    logic [DP_W-1:0]     r_acc, n_acc;
    logic [DP_W-1:0]     r_b, n_b;
    logic [DIV_W-1:0]    r_q, n_q;
    logic [DP_W-1:0]     r_num, n_num;
    logic [DP_W-1:0]     r_den, n_den;
    logic [MEAN_W-1:0]   r_mean, n_mean;
    logic [VAR_W-1:0]    r_var, n_var;
    logic [DEV_W-1:0]    r_dev, n_dev;

    // Output side
    logic                r_out_valid;

    // Shared add/subtract unit
    logic [DP_W-1:0]     alu_a, alu_b;
    logic                alu_sub;
    logic [DP_W:0]       alu_res;
    logic [DP_W-1:0]     alu_sum;
    logic                alu_ge;

    logic                        w_in_acc, w_out_acc, w_finish_go, w_last_step;
    logic                        w_has_room, w_var_ok;
    logic signed [2*SAMPLE_BITS-1:0] w_prod;
    logic [SUM_W-1:0]            w_smag;
    logic [SQSUM_W-1:0]          w_sumsq_now;
    logic [DP_W-1:0]             w_mul_acc, w_div_rem, w_root_rem, w_root_try;
    logic [DIV_W-1:0]            w_quot;
    logic [MEAN_W-1:0]           w_mean_mag;

    // Handshakes
    assign o_in_stall  = (r_state != ST_IDLE);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign w_out_acc   = r_out_valid && !i_out_stall;
    assign w_finish_go = (r_state == ST_FINISH) && (!r_out_valid || !i_out_stall);

    assign w_has_room = (r_count < COUNT_W'(MAX_SAMPLES));
    assign w_var_ok   = (r_count >= COUNT_W'(2));
    assign w_prod     = i_sample_value * i_sample_value;
    assign w_smag     = r_sum[SUM_W-1] ? (~r_sum + 1'b1) : r_sum;

    // Sum of squares with the pending square folded in
    assign w_sumsq_now = r_sq_pend ? (r_sumsq + SQSUM_W'(r_square)) : r_sumsq;

    // Accumulate; square is registered and folded in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_sum     <= '0;
            r_sumsq   <= '0;
            r_dropped <= 1'b0;
            r_sq_pend <= 1'b0;
        end else begin
            r_sq_pend <= 1'b0;
            r_sumsq   <= w_sumsq_now;
            if (w_in_acc) begin
                if (w_has_room) begin
                    r_count   <= r_count + 1'b1;
                    r_sum     <= r_sum + SUM_W'(i_sample_value);
                    r_sq_pend <= 1'b1;
                end else begin
                    r_dropped <= 1'b1;
                end
            end
            if (w_finish_go) begin
                r_count   <= '0;
                r_sum     <= '0;
                r_sumsq   <= '0;
                r_dropped <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_square <= w_prod[SQUARE_W-1:0];
        end
    end

    // Step operands
    assign w_div_rem  = {r_acc[DP_W-2:0], r_q[DIV_W-1]};
    assign w_root_rem = {r_acc[DP_W-3:0], r_q[RAD_W-1 -: 2]};
    assign w_root_try = {r_b[DP_W-3:0], 2'b01};

    // Operand select for the shared unit
    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state) inside
            ST_MUL_NSQ, ST_MUL_SS, ST_MUL_DEN: begin
                alu_a = r_acc;
                alu_b = r_b;
            end
            ST_SUB_NUM: begin
                alu_a   = r_num;
                alu_b   = r_acc;
                alu_sub = 1'b1;
            end
            ST_DIV_MEAN, ST_DIV_VAR: begin
                alu_a   = w_div_rem;
                alu_b   = r_b;
                alu_sub = 1'b1;
            end
            ST_SQRT: begin
                alu_a   = w_root_rem;
                alu_b   = w_root_try;
                alu_sub = 1'b1;
            end
            default: begin
                alu_a   = '0;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    // Carry out of a subtract means a >= b
    assign alu_res = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)}
                   + (DP_W+1)'(alu_sub);
    assign alu_sum = alu_res[DP_W-1:0];
    assign alu_ge  = alu_res[DP_W];

    assign w_last_step = (r_step == '0);
    assign w_mul_acc   = r_q[0] ? alu_sum : r_acc;
    assign w_quot      = {r_q[DIV_W-2:0], alu_ge};
    assign w_mean_mag  = w_quot[MEAN_W-1:0];

    // Sequencer: next state and working registers
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_acc   = r_acc;
        n_b     = r_b;
        n_q     = r_q;
        n_num   = r_num;
        n_den   = r_den;
        n_mean  = r_mean;
        n_var   = r_var;
        n_dev   = r_dev;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc && i_last_sample) begin
                    n_state = ST_START;
                end
            end
            // last square is folded in here; set up n * sumsq
            ST_START: begin
                n_acc   = '0;
                n_b     = DP_W'(w_sumsq_now);
                n_q     = DIV_W'(r_count);
                n_step  = t_step'(COUNT_W - 1);
                n_state = ST_MUL_NSQ;
            end
            ST_MUL_NSQ: begin
                n_acc  = w_mul_acc;
                n_b    = r_b << 1;
                n_q    = r_q >> 1;
                n_step = r_step - 1'b1;
                if (w_last_step) begin
                    n_num   = w_mul_acc;
                    n_acc   = '0;
                    n_b     = DP_W'(w_smag);
                    n_q     = DIV_W'(w_smag);
                    n_step  = t_step'(SUM_W - 1);
                    n_state = ST_MUL_SS;
                end
            end
            ST_MUL_SS: begin
                n_acc  = w_mul_acc;
                n_b    = r_b << 1;
                n_q    = r_q >> 1;
                n_step = r_step - 1'b1;
                if (w_last_step) begin
                    n_state = ST_SUB_NUM;
                end
            end
            // numerator n*sumsq - sum^2, then set up n*(n-1)
            ST_SUB_NUM: begin
                n_num   = alu_sum;
                n_acc   = '0;
                n_b     = DP_W'(r_count - 1'b1);
                n_q     = DIV_W'(r_count);
                n_step  = t_step'(COUNT_W - 1);
                n_state = ST_MUL_DEN;
            end
            ST_MUL_DEN: begin
                n_acc  = w_mul_acc;
                n_b    = r_b << 1;
                n_q    = r_q >> 1;
                n_step = r_step - 1'b1;
                if (w_last_step) begin
                    n_den   = w_mul_acc;
                    n_acc   = '0;
                    n_b     = DP_W'(r_count);
                    n_q     = DIV_W'(w_smag) << FRACTION_BITS;
                    n_step  = t_step'(DIV_W - 1);
                    n_state = ST_DIV_MEAN;
                end
            end
            // |sum| * 2^F / n, one quotient bit per cycle
            ST_DIV_MEAN: begin
                n_acc  = alu_ge ? alu_sum : w_div_rem;
                n_q    = w_quot;
                n_step = r_step - 1'b1;
                if (w_last_step) begin
                    n_mean = r_sum[SUM_W-1] ? (~w_mean_mag + 1'b1) : w_mean_mag;
                    if (w_var_ok) begin
                        n_acc   = '0;
                        n_b     = r_den;
                        n_q     = DIV_W'(r_num[NUM_W-1:0]) << (2 * FRACTION_BITS);
                        n_step  = t_step'(DIV_W - 1);
                        n_state = ST_DIV_VAR;
                    end else begin
                        n_var   = '0;
                        n_dev   = '0;
                        n_state = ST_FINISH;
                    end
                end
            end
            // variance at 2F fraction bits; the top part is the Q8 variance
            ST_DIV_VAR: begin
                n_acc  = alu_ge ? alu_sum : w_div_rem;
                n_q    = w_quot;
                n_step = r_step - 1'b1;
                if (w_last_step) begin
                    n_var   = w_quot[FRACTION_BITS +: VAR_W];
                    n_acc   = '0;
                    n_b     = '0;
                    n_q     = DIV_W'(w_quot[RAD_W-1:0]);
                    n_step  = t_step'(DEV_W - 1);
                    n_state = ST_SQRT;
                end
            end
            // restoring root, two radicand bits per cycle
            ST_SQRT: begin
                n_acc  = alu_ge ? alu_sum : w_root_rem;
                n_b    = {r_b[DP_W-2:0], alu_ge};
                n_q    = r_q << 2;
                n_step = r_step - 1'b1;
                if (w_last_step) begin
                    n_dev   = {r_b[DEV_W-2:0], alu_ge};
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (w_finish_go) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Sequencer control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // Working datapath registers
    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_b    <= n_b;
        r_q    <= n_q;
        r_num  <= n_num;
        r_den  <= n_den;
        r_mean <= n_mean;
        r_var  <= n_var;
        r_dev  <= n_dev;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
            if (w_finish_go) begin
                r_out_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish_go) begin
            o_sample_count      <= r_count;
            o_total_sum         <= r_sum;
            o_mean_q8           <= r_mean;
            o_variance_q8       <= r_var;
            o_deviation_q8      <= r_dev;
            o_variance_valid    <= w_var_ok;
            o_capacity_exceeded <= r_dropped;
        end
    end

    // Checks
`include "sample_statistics_unit_assert.svh"

    `SSU_CHECK_NEXT(a_last_starts_calc, w_in_acc && i_last_sample, r_state == ST_START, "no start")
    `SSU_CHECK_NOW(a_count_bound, 1'b1, r_count <= COUNT_W'(MAX_SAMPLES), "count over capacity")
    `SSU_CHECK_NOW(a_result_from_finish, $rose(o_out_valid), $past(r_state) == ST_FINISH, "bad load")
    `SSU_CHECK_NOW(a_single_zero, o_out_valid && !o_variance_valid, o_variance_q8 == '0 && o_deviation_q8 == '0, "nonzero var")

endmodule

>>> bench/sample_statistics_checker.sv
// ============================================================================
// sample_statistics_checker
// Watches both channels of the sample statistics unit. Keeps its own running
// count, sum and sum of squares, works out the closing statistics of every
// set it sees go in, and compares them field by field with the result beats
// that come out. Reports the number of mismatches and of results still owed.
// ============================================================================
module sample_statistics_checker
    import ssu_pkg::*;
(
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample_value,
    input  logic                          i_last_sample,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [COUNT_W-1:0]            i_sample_count,
    input  logic signed [SUM_W-1:0]       i_total_sum,
    input  logic signed [MEAN_W-1:0]      i_mean_q8,
    input  logic [VAR_W-1:0]              i_variance_q8,
    input  logic [DEV_W-1:0]              i_deviation_q8,
    input  logic                          i_variance_valid,
    input  logic                          i_capacity_exceeded,
    output int                            o_fail_count,
    output int                            o_pending
);

    // One set of closing statistics
    typedef struct {
        logic [COUNT_W-1:0]       count;
        logic signed [SUM_W-1:0]  sum;
        logic signed [MEAN_W-1:0] mean;
        logic [VAR_W-1:0]         variance;
        logic [DEV_W-1:0]         deviation;
        logic                     var_ok;
        logic                     dropped;
    } t_stats_result;

    // Running state of the set being collected
    logic [COUNT_W-1:0]      set_count;
    logic signed [SUM_W-1:0] set_sum;
    logic [SQSUM_W-1:0]      set_sqsum;
    logic                    set_dropped;

    t_stats_result owed_stats[$];
    t_stats_result oldest;
    int            mismatches = 0;

    // Floor of the square root, two radicand bits per pass
    function automatic logic [63:0] floor_root(input logic [63:0] radicand);
        logic [63:0] rest;
        logic [63:0] root;
        logic [63:0] probe;
        rest  = radicand;
        root  = '0;
        probe = 64'd1 << 62;
        while (probe > rest)
            probe = probe >> 2;
        while (probe != 0) begin
            if (rest >= root + probe) begin
                rest = rest - (root + probe);
                root = (root >> 1) + probe;
            end else begin
                root = root >> 1;
            end
            probe = probe >> 2;
        end
        return root;
    endfunction

    // Fold one accepted sample into the running state
    function automatic void add_sample(input logic signed [SAMPLE_BITS-1:0] value);
        logic signed [2*SAMPLE_BITS-1:0] square;
        square = value * value;
        if (set_count < MAX_SAMPLES) begin
            set_count = set_count + 1'b1;
            set_sum   = set_sum + value;
            set_sqsum = set_sqsum + square;
        end else begin
            set_dropped = 1'b1;
        end
    endfunction

    // Statistics of the set as it stands; variance by the exact sum-of-squares form
    function automatic t_stats_result close_set();
        t_stats_result     res;
        logic [63:0]       n;
        logic signed [63:0] wide_sum;
        logic [63:0]       sum_mag;
        logic [63:0]       mean_mag;
        logic [63:0]       mean_word;
        logic [63:0]       numer;
        logic [63:0]       denom;
        logic [63:0]       quot;
        logic [63:0]       remain;
        logic [63:0]       var_word;
        logic [63:0]       fine;
        n         = set_count;
        wide_sum  = set_sum;
        sum_mag   = (wide_sum < 0) ? -wide_sum : wide_sum;
        mean_mag  = (sum_mag << FRACTION_BITS) / n;
        mean_word = (wide_sum < 0) ? -mean_mag : mean_mag;
        var_word  = '0;
        fine      = '0;
        res.var_ok = (n >= 2);
        if (res.var_ok) begin
            numer    = n * set_sqsum - sum_mag * sum_mag;
            denom    = n * (n - 1);
            quot     = numer / denom;
            remain   = numer % denom;
            var_word = (quot << FRACTION_BITS) + ((remain << FRACTION_BITS) / denom);
            fine     = (quot << (2 * FRACTION_BITS))
                     + ((remain << (2 * FRACTION_BITS)) / denom);
        end
        res.count     = n[COUNT_W-1:0];
        res.sum       = set_sum;
        res.mean      = mean_word[MEAN_W-1:0];
        res.variance  = var_word[VAR_W-1:0];
        res.deviation = res.var_ok ? floor_root(fine) : '0;
        res.dropped   = set_dropped;
        return res;
    endfunction

    task automatic check_field(input string label, input logic signed [63:0] want,
                               input logic signed [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, want, got);
            mismatches++;
        end
    endtask

    // Sample the channels at the clock edge, predict and compare
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            set_count   = '0;
            set_sum     = '0;
            set_sqsum   = '0;
            set_dropped = 1'b0;
            owed_stats.delete();
        end else begin
            if (i_in_valid && !i_in_stall) begin
                add_sample(i_sample_value);
                if (i_last_sample) begin
                    owed_stats.push_back(close_set());
                    set_count   = '0;
                    set_sum     = '0;
                    set_sqsum   = '0;
                    set_dropped = 1'b0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (owed_stats.size() == 0) begin
                    $display("%0t: result beat with nothing expected, count %0d sum %0d",
                             $time, i_sample_count, i_total_sum);
                    mismatches++;
                end else begin
                    oldest = owed_stats.pop_front();
                    check_field("sample_count", oldest.count, i_sample_count);
                    check_field("total_sum", oldest.sum, i_total_sum);
                    check_field("mean_q8", oldest.mean, i_mean_q8);
                    check_field("variance_q8", oldest.variance, i_variance_q8);
                    check_field("deviation_q8", oldest.deviation, i_deviation_q8);
                    check_field("variance_valid", oldest.var_ok, i_variance_valid);
                    check_field("capacity_exceeded", oldest.dropped, i_capacity_exceeded);
                end
            end
        end
        o_pending    <= owed_stats.size();
        o_fail_count <= mismatches;
    end

endmodule

>>> bench/sample_statistics_unit_test.sv
// ============================================================================
// sample_statistics_unit_test
// Drives sets of signed samples into the sample statistics unit: a few
// hand-picked sets, then random sets of mostly short length with one set
// that overruns the capacity. Sender bursts and receiver stalls vary; the
// checker beside the block predicts and compares every result beat.
// ============================================================================
module sample_statistics_unit_test;
    import ssu_pkg::*;

    localparam int RANDOM_BEATS = 1700;
    localparam int BIG_SET_AT   = 12;
    localparam int DRAIN_AT     = 25;
    localparam int HOLD_CYCLES  = 800;
    localparam int SETTLE       = 250;
    localparam int CYCLE_LIMIT  = 1000000;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic signed [SAMPLE_BITS-1:0] sample_value = '0;
    logic last_sample = 1'b0;
    logic out_stall = 1'b0;
    logic hold_armed = 1'b0;

    logic                     in_stall;
    logic                     out_valid;
    logic [COUNT_W-1:0]       sample_count;
    logic signed [SUM_W-1:0]  total_sum;
    logic signed [MEAN_W-1:0] mean_q8;
    logic [VAR_W-1:0]         variance_q8;
    logic [DEV_W-1:0]         deviation_q8;
    logic                     variance_valid;
    logic                     capacity_exceeded;

    int fail_count;
    int pending;
    int beats_sent = 0;
    int burst_left = 1;

    sample_statistics_unit uut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_sample_value      (sample_value),
        .i_last_sample       (last_sample),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_sample_count      (sample_count),
        .o_total_sum         (total_sum),
        .o_mean_q8           (mean_q8),
        .o_variance_q8       (variance_q8),
        .o_deviation_q8      (deviation_q8),
        .o_variance_valid    (variance_valid),
        .o_capacity_exceeded (capacity_exceeded)
    );

    sample_statistics_checker stats_checker (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_sample_value      (sample_value),
        .i_last_sample       (last_sample),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_sample_count      (sample_count),
        .i_total_sum         (total_sum),
        .i_mean_q8           (mean_q8),
        .i_variance_q8       (variance_q8),
        .i_deviation_q8      (deviation_q8),
        .i_variance_valid    (variance_valid),
        .i_capacity_exceeded (capacity_exceeded),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("tb: failure");
        $finish;
    end

    // Sender pacing: bursts of random length, random gaps between them
    task automatic pace_sender();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            case ($urandom_range(0, 9))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(13, 40);
                default: gap = $urandom_range(1, 12);
            endcase
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 24);
        end
    endtask

    // Offer one sample beat and hold it until taken
    task automatic send_beat(input logic [SAMPLE_BITS-1:0] value, input logic closing);
        in_valid     <= 1'b1;
        sample_value <= value;
        last_sample  <= closing;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
        pace_sender();
    endtask

    // Stop offering and wait for every owed result beat
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // Sample value in one of several flavors
    function automatic logic [SAMPLE_BITS-1:0] pick_sample(input int flavor,
                                                           input logic [SAMPLE_BITS-1:0] base);
        logic [SAMPLE_BITS-1:0] pick;
        case (flavor)
            0: pick = SAMPLE_BITS'($urandom_range(0, 65535));
            1: begin
                case ($urandom_range(0, 4))
                    0:       pick = 16'h8000;
                    1:       pick = 16'h7fff;
                    2:       pick = 16'hffff;
                    3:       pick = 16'h0000;
                    default: pick = 16'h0001;
                endcase
            end
            2: pick = SAMPLE_BITS'($urandom_range(0, 16) - 8);
            default: pick = base + SAMPLE_BITS'($urandom_range(0, 6)) - SAMPLE_BITS'(3);
        endcase
        return pick;
    endfunction

    // Receiver: stall pattern of its own, one long hold-off when armed
    initial begin
        int cyc;
        int mode;
        int period;
        int on_len;
        logic held;
        cyc    = 0;
        mode   = 0;
        period = 4;
        on_len = 1;
        held   = 1'b0;
        @(posedge clk);
        forever begin
            if (hold_armed && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (cyc % 256 == 0) begin
                mode   = $urandom_range(0, 3);
                period = $urandom_range(2, 9);
                on_len = $urandom_range(1, period - 1);
            end
            case (mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 99) < 30);
                2:       out_stall <= ($urandom_range(0, 99) < 80);
                default: out_stall <= ((cyc % period) < on_len);
            endcase
            cyc++;
            @(posedge clk);
        end
    end

    // Stimulus and verdict
    initial begin
        int set_no;
        int set_len;
        int flavor;
        int extra;
        int big_mode;
        logic [SAMPLE_BITS-1:0] base;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-sample sets: variance reported invalid
        send_beat(16'h0000, 1'b1);
        send_beat(16'h8000, 1'b1);
        send_beat(16'h7fff, 1'b1);
        // Two extremes: widest spread for a pair
        send_beat(16'h7fff, 1'b0);
        send_beat(16'h8000, 1'b1);
        // Equal negative extremes: zero variance
        send_beat(16'h8000, 1'b0);
        send_beat(16'h8000, 1'b1);
        // Fractional mean and variance
        send_beat(16'h0001, 1'b0);
        send_beat(16'h0002, 1'b0);
        send_beat(16'h0004, 1'b1);
        // Negative mean truncated toward zero
        send_beat(16'hffff, 1'b0);
        send_beat(16'hffff, 1'b0);
        send_beat(16'h0000, 1'b1);
        // All positive extremes
        send_beat(16'h7fff, 1'b0);
        send_beat(16'h7fff, 1'b0);
        send_beat(16'h7fff, 1'b0);
        send_beat(16'h7fff, 1'b1);

        // Random sets
        beats_sent = 0;
        set_no     = 0;
        while (beats_sent < RANDOM_BEATS) begin
            if (set_no == 3)
                hold_armed <= 1'b1;
            if (set_no == BIG_SET_AT) begin
                // Full capacity, then samples that must be dropped
                big_mode = $urandom_range(0, 2);
                for (int k = 0; k < MAX_SAMPLES; k++) begin
                    case (big_mode)
                        0:       send_beat((k % 2) ? 16'h8000 : 16'h7fff, 1'b0);
                        1:       send_beat(16'h8000, 1'b0);
                        default: send_beat(16'h7fff, 1'b0);
                    endcase
                end
                extra = $urandom_range(1, 6);
                for (int k = 0; k < extra; k++)
                    send_beat(SAMPLE_BITS'($urandom_range(0, 65535)), k == extra - 1);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: set_len = $urandom_range(1, 6);
                    6, 7, 8:          set_len = $urandom_range(7, 32);
                    default:          set_len = $urandom_range(33, 100);
                endcase
                flavor = $urandom_range(0, 3);
                base   = SAMPLE_BITS'($urandom_range(0, 65535));
                for (int k = 0; k < set_len; k++)
                    send_beat(pick_sample(flavor, base), k == set_len - 1);
            end
            if (set_no == DRAIN_AT)
                drain_results();
            set_no++;
        end

        drain_results();
        repeat (SETTLE) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/ssu_pkg.sv
hw/rtl/sample_statistics_unit.sv
bench/sample_statistics_checker.sv
bench/sample_statistics_unit_test.sv
